/* rtl/assert_macros.svh */
// Assertion macros for the checker file of the deque block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, switched off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/bldq_pkg.sv */
// Package of shared types and constants for the bounded deque block.
`timescale 1ns / 1ps

package bldq_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam int REQ_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FIELD_W  = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_COUNT      = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // What a cell loads at the next edge.
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_FROM_LEFT  = 2'd1,
        CELL_FROM_RIGHT = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

endpackage

/* rtl/bldq_cell.sv */
// One storage cell of the deque chain.
`timescale 1ns / 1ps

module bldq_cell
    import bldq_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_op                  i_op,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic signed [VALUE_W-1:0] i_right,
    input  logic signed [VALUE_W-1:0] i_load,
    output logic signed [VALUE_W-1:0] o_value
);

    logic signed [VALUE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_op)
            CELL_FROM_LEFT:  r_value <= i_left;
            CELL_FROM_RIGHT: r_value <= i_right;
            CELL_LOAD:       r_value <= i_load;
            default:         r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

/* rtl/bounded_list_deque_with_count_search_unit.sv */
// Top level of the bounded deque with front/back insert, remove and count search.
`timescale 1ns / 1ps

// The list lives in a row of DEPTH cells, the front entry always in cell 0 and
// the back entry in the cell just below the occupancy. Inserts, removes and
// unused request codes finish in the cycle they are accepted, so while no
// result is stalled they run at one item per cycle. A count request rotates
// the whole row once round, comparing cell 0 against the value on each step,
// and no new item is accepted until the rotation is done and its result is
// registered; the rotation leaves the row exactly as it found it. A stalled
// result holds the block for as long as the stall lasts.
module bounded_list_deque_with_count_search_unit
    import bldq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [REQ_W-1:0]           i_req_type,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic [FIELD_W-1:0]         o_match_count,
    output logic [FIELD_W-1:0]         o_occupancy
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(DEPTH - 1);

    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_step, n_step;
    logic [CNT_W-1:0]          r_matches, n_matches;
    logic signed [VALUE_W-1:0] r_value, n_value;

    logic                      r_out_valid, n_out_valid;
    t_status                   r_out_status, n_out_status;
    logic [FIELD_W-1:0]        r_out_match, n_out_match;
    logic [FIELD_W-1:0]        r_out_occ, n_out_occ;

    t_cell_op                  w_ops [DEPTH];
    logic signed [VALUE_W-1:0] w_cell [DEPTH];

    logic w_out_free;
    logic w_accept;
    logic w_full;
    logic w_empty;
    logic w_hit;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);
    // Cell 0 holds the entry r_step places from the front during the scan.
    assign w_hit      = (CNT_W'(r_step) < r_count) && (w_cell[0] == r_value);

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_step       = r_step;
        n_matches    = r_matches;
        n_value      = r_value;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_match  = r_out_match;
        n_out_occ    = r_out_occ;
        for (int i = 0; i < DEPTH; i++) begin
            w_ops[i] = CELL_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_status = ST_OK;
                    case (i_req_type)
                        REQ_PUSH_FRONT: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_ops[i] = CELL_FROM_LEFT;
                                end
                                w_ops[0] = CELL_LOAD;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        REQ_PUSH_BACK: begin
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_ops[r_count[IDX_W-1:0]] = CELL_LOAD;
                                n_count = r_count + 1'b1;
                            end
                        end
                        REQ_POP_FRONT: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    w_ops[i] = CELL_FROM_RIGHT;
                                end
                                n_count = r_count - 1'b1;
                            end
                        end
                        REQ_POP_BACK: begin
                            if (w_empty) begin
                                n_out_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        REQ_COUNT: begin
                            n_value   = i_value;
                            n_step    = '0;
                            n_matches = '0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                    if (i_req_type != REQ_COUNT) begin
                        n_out_valid = 1'b1;
                        n_out_match = '0;
                        n_out_occ   = FIELD_W'(n_count);
                    end
                end
            end
            S_SCAN: begin
                for (int i = 0; i < DEPTH; i++) begin
                    w_ops[i] = CELL_FROM_RIGHT;
                end
                n_matches = r_matches + CNT_W'(w_hit);
                n_step    = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    if (w_out_free) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_OK;
                        n_out_match  = FIELD_W'(n_matches);
                        n_out_occ    = FIELD_W'(r_count);
                        n_state      = S_IDLE;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = ST_OK;
                    n_out_match  = FIELD_W'(r_matches);
                    n_out_occ    = FIELD_W'(r_count);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step       <= n_step;
        r_matches    <= n_matches;
        r_value      <= n_value;
        r_out_status <= n_out_status;
        r_out_match  <= n_out_match;
        r_out_occ    <= n_out_occ;
    end

    // The row closes into a ring so that a full rotation restores it.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bldq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_ops[g]),
            .i_left  (w_cell[(g + DEPTH - 1) % DEPTH]),
            .i_right (w_cell[(g + 1) % DEPTH]),
            .i_load  (i_value),
            .o_value (w_cell[g])
        );
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_match_count = r_out_match;
    assign o_occupancy   = r_out_occ;

endmodule

/* rtl/bldq_chk.sv */
// Port-level checker for the bounded deque, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bldq_chk
    import bldq_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic [STATUS_W-1:0]       o_status,
    input logic [FIELD_W-1:0]        o_match_count,
    input logic [FIELD_W-1:0]        o_occupancy
);

    // A held result keeps its payload until it is taken.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_status) && $stable(o_match_count) && $stable(o_occupancy))

    // A result that cannot leave keeps the input closed.
    `ASSERT_IMPLIES(a_in_closed, i_clk, i_rst_n, o_out_valid && i_out_stall, o_in_stall)

    // A refused insert reports a full store.
    `ASSERT_IMPLIES(a_full_occ, i_clk, i_rst_n, o_out_valid && o_status == ST_FULL,
        o_occupancy == FIELD_W'(DEPTH))

    // A refused removal reports an empty store and no matches.
    `ASSERT_IMPLIES(a_empty_occ, i_clk, i_rst_n, o_out_valid && o_status == ST_EMPTY,
        o_occupancy == '0 && o_match_count == '0)

    // Matches only come from a count request, which never fails.
    `ASSERT_IMPLIES(a_match_ok, i_clk, i_rst_n, o_out_valid && o_match_count != '0,
        o_status == ST_OK)

endmodule

bind bounded_list_deque_with_count_search_unit bldq_chk u_bldq_chk (.*);
